/* design/ptc_pkg.sv */
// Package for the pressure/temperature compensation block.
// Holds field widths, compensation constants and configuration register indexes.
// No dependencies.
package ptc_pkg;

	localparam int RAW_W   = 24;
	localparam int CAL_W   = 16;
	localparam int TEMP_W  = 19;
	localparam int PRES_W  = 32;
	localparam int IDX_W   = 3;

	localparam int DT_W    = RAW_W + 1;
	localparam int SENS_W  = 39;
	localparam int OFF_W   = 40;
	localparam int SPLIT_W = 20;
	localparam int PP_W    = RAW_W + SPLIT_W;
	localparam int PROD_W  = 63;

	localparam int SENS_SHIFT = 21;
	localparam int PRES_SHIFT = 13;

	localparam logic signed [TEMP_W-1:0] TEMP_REF_CENTI      = 19'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_VERY_LOW_CENTI = 19'sd1500;

	typedef enum logic [IDX_W-1:0] {
		CFG_PRESSURE_SENSITIVITY   = 3'd0,
		CFG_PRESSURE_OFFSET        = 3'd1,
		CFG_SENSITIVITY_TEMP_COEFF = 3'd2,
		CFG_OFFSET_TEMP_COEFF      = 3'd3,
		CFG_REFERENCE_TEMPERATURE  = 3'd4,
		CFG_TEMPERATURE_COEFF      = 3'd5
	} cfg_idx_t;

endpackage

/* design/ptc_pmul.sv */
// Two-stage multiplier for raw pressure times corrected sensitivity.
// Splits the signed sensitivity into two partial products. Depends on ptc_pkg.
module ptc_pmul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid_in,
	input  logic [ptc_pkg::RAW_W-1:0]            d1_in,
	input  logic signed [ptc_pkg::SENS_W-1:0]    sens_in,
	output logic                                 valid_out,
	output logic signed [ptc_pkg::PROD_W-1:0]    prod_out
);
	import ptc_pkg::*;

	logic                     valid_s1;
	logic [PP_W-1:0]          pp_lo_s1;
	logic signed [PP_W-1:0]   pp_hi_s1;
	logic [PP_W-1:0]          pp_lo_c;
	logic signed [PP_W-1:0]   pp_hi_c;
	logic signed [PROD_W-1:0] hi_ext;
	logic signed [PROD_W-1:0] lo_ext;

	assign pp_lo_c = d1_in * sens_in[SPLIT_W-1:0];
	assign pp_hi_c = $signed({1'b0, d1_in}) * $signed(sens_in[SENS_W-1:SPLIT_W]);

	assign hi_ext = {pp_hi_s1[PROD_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}};
	assign lo_ext = {{(PROD_W-PP_W){1'b0}}, pp_lo_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_out <= 1'b0;
		end else begin
			valid_s1  <= valid_in;
			valid_out <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pp_lo_s1 <= pp_lo_c;
		pp_hi_s1 <= pp_hi_c;
		prod_out <= hi_ext + lo_ext;
	end

	a_valid_delay: assert property (@(posedge clk) disable iff (!arst_n)
		valid_in |-> ##2 valid_out)
		else $error("multiplier dropped a valid input");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out |-> $past(valid_in, 2))
		else $error("multiplier valid out of step with its input");

	a_hi_sign: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !$past(sens_in[SENS_W-1]) |-> !pp_hi_s1[PP_W-1])
		else $error("upper partial product negative for non-negative sensitivity");

	a_zero_d1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && ($past(d1_in, 2) == '0) |-> prod_out == '0)
		else $error("zero pressure gave nonzero product");

endmodule

/* design/pressure_temperature_compensation_unit.sv */
// Top level of the pressure/temperature compensation block.
// Depends on ptc_pkg and ptc_pmul.
//
// Usage:
//   Calibration: write the six 16-bit factory words through cfg_valid/cfg_ready,
//   cfg_index selects the word (0..5), cfg_data carries it. Indexes 6 and 7 are
//   dropped. Write them only while no request is in flight.
//   Requests: drive raw_pressure and raw_temperature and raise start; the
//   request is taken at a clock edge where start is high and busy is low.
//   A new request may be taken at every clock edge.
//   Results: done is high for exactly one cycle with temperature_centi and
//   pressure_tenth_mbar; the receiver cannot hold results off.
// Pipeline and throughput:
//   Nine register stages. One request per cycle is sustained; the pipeline
//   never stalls. The long poles are the 25x25 delta square and the 24x39
//   pressure product, which is split into two partial products over two
//   stages.
// Reset:
//   arst_n clears all calibration words to zero and drops every in-flight
//   request. busy stays high for the first cycle after reset.
module pressure_temperature_compensation_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [ptc_pkg::IDX_W-1:0]               cfg_index,
	input  logic [ptc_pkg::CAL_W-1:0]               cfg_data,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [ptc_pkg::RAW_W-1:0]               raw_pressure,
	input  logic [ptc_pkg::RAW_W-1:0]               raw_temperature,
	output logic                                    done,
	output logic signed [ptc_pkg::TEMP_W-1:0]       temperature_centi,
	output logic signed [ptc_pkg::PRES_W-1:0]       pressure_tenth_mbar
);
	import ptc_pkg::*;

	// calibration words
	logic [CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic             rdy_q;
	logic             accept;

	// stage 1: temperature delta
	logic                     v_s1;
	logic signed [DT_W-1:0]   dt_s1;
	logic [RAW_W-1:0]         d1_s1;

	// stage 2: first-order products and delta square
	logic                     v_s2;
	logic signed [41:0]       pt_s2, poff_s2, psens_s2;
	logic [47:0]              dtsq_s2;
	logic [RAW_W-1:0]         d1_s2;
	logic signed [41:0]       pt_c, poff_c, psens_c;
	logic signed [49:0]       dtsq_c;

	// stage 3: first-order values
	logic                     v_s3;
	logic signed [TEMP_W-1:0] temp_s3, lo_s3, vl_s3;
	logic signed [35:0]       off_s3;
	logic signed [34:0]       sens_s3;
	logic [16:0]              ti_s3;
	logic                     cold_s3, vcold_s3;
	logic [RAW_W-1:0]         d1_s3;
	logic [49:0]              ti3_c;
	logic signed [TEMP_W-1:0] temp_c;

	// stage 4: squares of the low-temperature terms
	logic                     v_s4;
	logic [34:0]              losq_s4, vlsq_s4;
	logic signed [TEMP_W-1:0] temp_s4;
	logic signed [35:0]       off_s4;
	logic signed [34:0]       sens_s4;
	logic [16:0]              ti_s4;
	logic                     cold_s4, vcold_s4;
	logic [RAW_W-1:0]         d1_s4;
	logic signed [37:0]       losq_c, vlsq_c;

	// stage 5: second-order corrections
	logic                     v_s5;
	logic [38:0]              offi_s5;
	logic [37:0]              sensi_s5;
	logic signed [TEMP_W-1:0] temp_s5;
	logic signed [35:0]       off_s5;
	logic signed [34:0]       sens_s5;
	logic                     cold_s5;
	logic [RAW_W-1:0]         d1_s5;
	logic [36:0]              lo3_c;
	logic [37:0]              lo5_c, vl7_c;
	logic [38:0]              offi_c;
	logic [37:0]              sensi_c;

	// stage 6: corrected offset and sensitivity
	logic                     v_s6;
	logic signed [OFF_W-1:0]  off_s6;
	logic signed [SENS_W-1:0] sens_s6;
	logic signed [TEMP_W-1:0] temp_s6;
	logic [RAW_W-1:0]         d1_s6;

	// stages 7 and 8 run inside the multiplier; carry side data alongside
	logic signed [OFF_W-1:0]  off_s7, off_s8;
	logic signed [TEMP_W-1:0] temp_s7, temp_s8;
	logic                     v_s8;
	logic signed [PROD_W-1:0] prod_s8;

	// stage 9: final pressure
	logic signed [44:0]       pdiff_c;

	assign accept    = start && !busy;
	assign busy      = !rdy_q;
	assign cfg_ready = rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q <= 1'b0;
		end else begin
			rdy_q <= 1'b1;
		end
	end

	// calibration register file; drop writes to unused indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PRESSURE_SENSITIVITY:   c1_q <= cfg_data;
				CFG_PRESSURE_OFFSET:        c2_q <= cfg_data;
				CFG_SENSITIVITY_TEMP_COEFF: c3_q <= cfg_data;
				CFG_OFFSET_TEMP_COEFF:      c4_q <= cfg_data;
				CFG_REFERENCE_TEMPERATURE:  c5_q <= cfg_data;
				CFG_TEMPERATURE_COEFF:      c6_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits advance every cycle; nothing downstream can stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			done <= v_s8;
		end
	end

	// stage 2 products; operands are sign- or zero-extended to the product width
	assign pt_c    = dt_s1 * $signed({1'b0, c6_q});
	assign poff_c  = dt_s1 * $signed({1'b0, c4_q});
	assign psens_c = dt_s1 * $signed({1'b0, c3_q});
	assign dtsq_c  = dt_s1 * dt_s1;

	// stage 3: floor shifts are slices of the signed products
	assign temp_c = TEMP_REF_CENTI + $signed(pt_s2[41:23]);
	assign ti3_c  = {2'b00, dtsq_s2} + {1'b0, dtsq_s2, 1'b0};

	// stage 4 squares
	assign losq_c = lo_s3 * lo_s3;
	assign vlsq_c = vl_s3 * vl_s3;

	// stage 5: 3/2 and 5/8 of the low square, 7x and 4x of the very-low square
	assign lo3_c   = {2'b00, losq_s4} + {1'b0, losq_s4, 1'b0};
	assign lo5_c   = {3'b000, losq_s4} + {1'b0, losq_s4, 2'b00};
	assign vl7_c   = {vlsq_s4, 3'b000} - {3'b000, vlsq_s4};
	assign offi_c  = {3'b000, lo3_c[36:1]} + (vcold_s4 ? {1'b0, vl7_c} : 39'd0);
	assign sensi_c = {3'b000, lo5_c[37:3]} + (vcold_s4 ? {1'b0, vlsq_s4, 2'b00} : 38'd0);

	always_ff @(posedge clk) begin
		// stage 1
		dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_q, 8'h00});
		d1_s1 <= raw_pressure;
		// stage 2
		pt_s2    <= pt_c;
		poff_s2  <= poff_c;
		psens_s2 <= psens_c;
		dtsq_s2  <= dtsq_c[47:0];
		d1_s2    <= d1_s1;
		// stage 3
		temp_s3  <= temp_c;
		lo_s3    <= $signed(pt_s2[41:23]);
		vl_s3    <= temp_c + TEMP_VERY_LOW_CENTI;
		cold_s3  <= pt_s2[41];
		vcold_s3 <= temp_c < -TEMP_VERY_LOW_CENTI;
		ti_s3    <= ti3_c[49:33];
		off_s3   <= $signed({4'h0, c2_q, 16'h0000}) + $signed({poff_s2[41], poff_s2[41:7]});
		sens_s3  <= $signed({4'h0, c1_q, 15'h0000}) + $signed({psens_s2[41], psens_s2[41:8]});
		d1_s3    <= d1_s2;
		// stage 4
		losq_s4  <= losq_c[34:0];
		vlsq_s4  <= vlsq_c[34:0];
		temp_s4  <= temp_s3;
		off_s4   <= off_s3;
		sens_s4  <= sens_s3;
		ti_s4    <= ti_s3;
		cold_s4  <= cold_s3;
		vcold_s4 <= vcold_s3 && cold_s3;
		d1_s4    <= d1_s3;
		// stage 5: corrections apply only below the reference temperature
		offi_s5  <= cold_s4 ? offi_c : 39'd0;
		sensi_s5 <= cold_s4 ? sensi_c : 38'd0;
		temp_s5  <= cold_s4 ? temp_s4 - $signed({2'b00, ti_s4}) : temp_s4;
		off_s5   <= off_s4;
		sens_s5  <= sens_s4;
		cold_s5  <= cold_s4;
		d1_s5    <= d1_s4;
		// stage 6
		off_s6  <= {{4{off_s5[35]}}, off_s5} - {1'b0, offi_s5};
		sens_s6 <= {{4{sens_s5[34]}}, sens_s5} - {1'b0, sensi_s5};
		temp_s6 <= temp_s5;
		d1_s6   <= d1_s5;
		// hold side data in step with the multiplier
		off_s7  <= off_s6;
		off_s8  <= off_s7;
		temp_s7 <= temp_s6;
		temp_s8 <= temp_s7;
		// stage 9: keep the low 32 bits of the final floor shift
		temperature_centi   <= temp_s8;
		pressure_tenth_mbar <= pdiff_c[PRES_W+PRES_SHIFT-1:PRES_SHIFT];
	end

	ptc_pmul u_pmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (v_s6),
		.d1_in     (d1_s6),
		.sens_in   (sens_s6),
		.valid_out (v_s8),
		.prod_out  (prod_s8)
	);

	assign pdiff_c = {{3{prod_s8[PROD_W-1]}}, prod_s8[PROD_W-1:SENS_SHIFT]}
		- {{5{off_s8[OFF_W-1]}}, off_s8};

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##9 done)
		else $error("accepted request produced no result nine cycles later");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 9))
		else $error("result without a matching request");

	a_cold_temp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && cold_s5 |-> temp_s5 < TEMP_REF_CENTI)
		else $error("second-order temperature at or above reference");

endmodule
